FILE: rtl/core/nrt_pkg.sv
// shared types, codes and number helpers for the number redirect table
package nrt_pkg;

  // fixed field widths
  localparam int NUM_W   = 64;
  localparam int DIG_W   = 60;
  localparam int LEN_W   = 4;
  localparam int OWN_W   = 2;
  localparam int MEM_W   = OWN_W + 2 * NUM_W;
  localparam int NIBBLES = DIG_W / 4;

  // operation codes
  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_DELETE    = 3'd1;
  localparam logic [2:0] OP_INSERT    = 3'd2;
  localparam logic [2:0] OP_ERASE     = 3'd3;
  localparam logic [2:0] OP_TRANSFORM = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOMAP   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DEL_RD,
    S_DEL_CMP,
    S_CNT_RD,
    S_CNT_CMP,
    S_FND_RD,
    S_FND_CMP,
    S_APPLY,
    S_FINISH
  } nrt_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       scan_init;
    logic       del_cmp;
    logic       cnt_cmp;
    logic       fnd_cmp;
    logic       do_create;
    logic       do_unmap;
    logic       do_write;
    logic       do_erase;
    logic       do_follow;
    logic       do_cyc;
    logic       res_en;
    logic       set_status;
    logic [2:0] status;
    logic       finish;
  } nrt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       src_ok;
    logic       dst_ok;
    logic       known;
    logic       found;
    logic       free_found;
    logic       last;
    logic       steps_over;
    logic       out_free;
  } nrt_stat_t;

  // canonical number {ok, digits masked past len, len}
  function automatic logic [NUM_W:0] canon(input logic [DIG_W-1:0] d,
                                           input logic [LEN_W-1:0] len,
                                           input int maxd);
    logic [DIG_W-1:0] keep;
    logic             ok;
    keep = '0;
    ok   = (len != '0) && (int'(len) <= maxd);
    for (int i = 0; i < NIBBLES; i++) begin
      if (i < int'(len)) begin
        keep[DIG_W-1-4*i -: 4] = 4'hF;
        if (d[DIG_W-1-4*i -: 4] > 4'd9) ok = 1'b0;
      end
    end
    return {ok, d & keep, len};
  endfunction

endpackage

FILE: rtl/core/nrt_ctrl.sv
// sequencing state machine for the number redirect table
module nrt_ctrl
  import nrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  nrt_stat_t stat,
  output nrt_cmd_t  cmd
);

  nrt_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.op) inside
          OP_CREATE: state_nxt = S_FINISH;
          OP_DELETE: state_nxt = stat.known ? S_DEL_RD : S_FINISH;
          OP_INSERT, OP_ERASE, OP_TRANSFORM: begin
            if (!stat.src_ok || (stat.op == OP_INSERT && !stat.dst_ok) || !stat.known)
              state_nxt = S_FINISH;
            else if (stat.op == OP_TRANSFORM)
              state_nxt = S_CNT_RD;
            else
              state_nxt = S_FND_RD;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_DEL_RD:  state_nxt = S_DEL_CMP;
      S_DEL_CMP: state_nxt = stat.last ? S_FINISH : S_DEL_RD;
      S_CNT_RD:  state_nxt = S_CNT_CMP;
      S_CNT_CMP: state_nxt = stat.last ? S_FND_RD : S_CNT_RD;
      S_FND_RD:  state_nxt = S_FND_CMP;
      S_FND_CMP: state_nxt = stat.last ? S_APPLY : S_FND_RD;
      S_APPLY: begin
        if (stat.op == OP_TRANSFORM && stat.found && !stat.steps_over)
          state_nxt = S_FND_RD;
        else
          state_nxt = S_FINISH;
      end
      S_FINISH: if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.accept = in_valid;
      S_DECODE: begin
        case (stat.op) inside
          OP_CREATE: cmd.do_create = 1'b1;
          OP_DELETE: begin
            if (stat.known) begin
              cmd.scan_init = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNKNOWN;
            end
          end
          OP_INSERT, OP_ERASE, OP_TRANSFORM: begin
            if (!stat.src_ok || (stat.op == OP_INSERT && !stat.dst_ok)) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_INVALID;
            end else if (!stat.known) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNKNOWN;
            end else begin
              cmd.scan_init = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DEL_RD: ;
      S_DEL_CMP: begin
        cmd.del_cmp  = 1'b1;
        cmd.do_unmap = stat.last;
      end
      S_CNT_RD: ;
      S_CNT_CMP: begin
        cmd.cnt_cmp   = 1'b1;
        cmd.scan_init = stat.last;
      end
      S_FND_RD:  ;
      S_FND_CMP: cmd.fnd_cmp = 1'b1;
      S_APPLY: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.found || stat.free_found) begin
              cmd.do_write = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end
          end
          OP_ERASE: cmd.do_erase = 1'b1;
          default: begin
            if (!stat.found) begin
              cmd.res_en = 1'b1;
            end else if (stat.steps_over) begin
              cmd.do_cyc = 1'b1;
            end else begin
              cmd.do_follow = 1'b1;
              cmd.scan_init = 1'b1;
            end
          end
        endcase
      end
      S_FINISH: cmd.finish = stat.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/nrt_dpath.sv
// table storage, scan logic and result registers of the number redirect table
module nrt_dpath
  import nrt_pkg::*;
#(
  parameter int MAX_DIGITS = 15,
  parameter int ENTRIES    = 64,
  parameter int MAPS       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nrt_cmd_t         cmd,
  output nrt_stat_t        stat,
  input  logic [2:0]       in_op,
  input  logic [1:0]       in_map_id,
  input  logic [DIG_W-1:0] in_src_digits,
  input  logic [LEN_W-1:0] in_src_len,
  input  logic [DIG_W-1:0] in_dst_digits,
  input  logic [LEN_W-1:0] in_dst_len,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [1:0]       out_new_map,
  output logic [DIG_W-1:0] out_result_digits,
  output logic [LEN_W-1:0] out_result_len,
  output logic             out_cycle_found
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 2);
  localparam int SW = (MAPS > 1) ? $clog2(MAPS) : 1;

  // table memory {owner, key, target}
  logic [MEM_W-1:0] mem [ENTRIES];
  logic [MEM_W-1:0] rd_r;
  logic [ENTRIES-1:0] valid_r;
  logic [MAPS-1:0] in_use_r;

  // transaction registers
  logic [2:0]       op_r;
  logic [1:0]       id_r;
  logic [NUM_W-1:0] src_r, dst_r, cur_r, tgt_r, res_r;
  logic             src_ok_r, dst_ok_r;
  logic [2:0]       status_r;
  logic [1:0]       new_map_r;
  logic             cyc_r;

  // scan registers
  logic [IW-1:0] idx_r, hit_r, free_r;
  logic          found_r, free_found_r;
  logic [CW-1:0] count_r, steps_r;

  // output registers
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [1:0]       out_new_map_r;
  logic [NUM_W-1:0] out_res_r;
  logic             out_cyc_r;

  logic [NUM_W:0] src_c, dst_c;
  logic [OWN_W-1:0] rd_owner;
  logic [NUM_W-1:0] rd_key, rd_tgt;
  logic own_match, hit, known, free_any;
  logic [SW-1:0] free_slot;
  logic [IW-1:0] widx;
  logic [CW-1:0] steps_inc;

  assign src_c = canon(in_src_digits, in_src_len, MAX_DIGITS);
  assign dst_c = canon(in_dst_digits, in_dst_len, MAX_DIGITS);

  assign rd_owner  = rd_r[MEM_W-1 -: OWN_W];
  assign rd_key    = rd_r[2*NUM_W-1 -: NUM_W];
  assign rd_tgt    = rd_r[NUM_W-1:0];
  assign own_match = valid_r[idx_r] && (rd_owner == id_r);
  assign hit       = own_match && (rd_key == cur_r);
  assign widx      = found_r ? hit_r : free_r;
  assign steps_inc = steps_r + CW'(1);

  // map lookup and lowest free slot
  always_comb begin
    known     = 1'b0;
    free_any  = 1'b0;
    free_slot = '0;
    for (int m = 0; m < MAPS; m++) begin
      if (in_use_r[m] && int'(id_r) == m) known = 1'b1;
    end
    for (int m = MAPS - 1; m >= 0; m--) begin
      if (!in_use_r[m]) begin
        free_any  = 1'b1;
        free_slot = SW'(m);
      end
    end
  end

  // status to controller
  always_comb begin
    stat.op         = op_r;
    stat.src_ok     = src_ok_r;
    stat.dst_ok     = dst_ok_r;
    stat.known      = known;
    stat.found      = found_r;
    stat.free_found = free_found_r;
    stat.last       = (idx_r == IW'(ENTRIES - 1));
    stat.steps_over = (steps_inc > count_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.do_write) mem[widx] <= {id_r, src_r, dst_r};
    rd_r <= mem[idx_r];
  end

  // valid marks and map slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      in_use_r <= '0;
    end else begin
      if (cmd.del_cmp && own_match) valid_r[idx_r] <= 1'b0;
      if (cmd.do_write) valid_r[widx] <= 1'b1;
      if (cmd.do_erase && found_r) valid_r[hit_r] <= 1'b0;
      if (cmd.do_create && free_any) in_use_r[free_slot] <= 1'b1;
      if (cmd.do_unmap) begin
        for (int m = 0; m < MAPS; m++) begin
          if (int'(id_r) == m) in_use_r[m] <= 1'b0;
        end
      end
    end
  end

  // transaction and scan state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_op;
      id_r      <= in_map_id;
      src_ok_r  <= src_c[NUM_W];
      src_r     <= src_c[NUM_W-1:0];
      cur_r     <= src_c[NUM_W-1:0];
      dst_ok_r  <= dst_c[NUM_W];
      dst_r     <= dst_c[NUM_W-1:0];
      status_r  <= ST_OK;
      new_map_r <= '0;
      res_r     <= '0;
      cyc_r     <= 1'b0;
      count_r   <= '0;
      steps_r   <= '0;
    end
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.do_create) begin
      if (free_any) new_map_r <= 2'(free_slot);
      else          status_r  <= ST_NOMAP;
    end
    if (cmd.scan_init) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (cmd.scan_init) idx_r <= '0;
    else if (cmd.del_cmp || cmd.cnt_cmp || cmd.fnd_cmp) idx_r <= idx_r + IW'(1);
    if (cmd.cnt_cmp && own_match) count_r <= count_r + CW'(1);
    if (cmd.fnd_cmp) begin
      if (hit) begin
        found_r <= 1'b1;
        hit_r   <= idx_r;
        tgt_r   <= rd_tgt;
      end
      if (!valid_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= idx_r;
      end
    end
    // chain walk
    if (cmd.do_follow) begin
      cur_r   <= tgt_r;
      steps_r <= steps_inc;
    end
    if (cmd.res_en) res_r <= cur_r;
    if (cmd.do_cyc) begin
      res_r <= src_r;
      cyc_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_status_r  <= status_r;
      out_new_map_r <= new_map_r;
      out_res_r     <= res_r;
      out_cyc_r     <= cyc_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_map       = out_new_map_r;
  assign out_result_digits = out_res_r[NUM_W-1:LEN_W];
  assign out_result_len    = out_res_r[LEN_W-1:0];
  assign out_cycle_found   = out_cyc_r;

endmodule

FILE: rtl/core/number_redirect_table_unit.sv
// number redirect table: top level joining controller and datapath
// create and error cases finish without a scan; delete, insert and erase scan the table once;
// transform counts the map's entries in one scan, then scans once per chain step; each entry
// is read through the single registered memory read port in an RD state, then compared in a CMP state
// one transaction at a time; the next one is taken while the result waits
// synchronous active-low reset clears valid marks and map slots, no clearing pass
module number_redirect_table_unit
  import nrt_pkg::*;
#(
  parameter int MAX_DIGITS = 15,
  parameter int ENTRIES    = 64,
  parameter int MAPS       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [1:0]       in_map_id,
  input  logic [DIG_W-1:0] in_src_digits,
  input  logic [LEN_W-1:0] in_src_len,
  input  logic [DIG_W-1:0] in_dst_digits,
  input  logic [LEN_W-1:0] in_dst_len,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [1:0]       out_new_map,
  output logic [DIG_W-1:0] out_result_digits,
  output logic [LEN_W-1:0] out_result_len,
  output logic             out_cycle_found
);

  nrt_cmd_t  cmd;
  nrt_stat_t stat;

  // sequencer
  nrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and datapath
  nrt_dpath #(
    .MAX_DIGITS (MAX_DIGITS),
    .ENTRIES    (ENTRIES),
    .MAPS       (MAPS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_map_id         (in_map_id),
    .in_src_digits     (in_src_digits),
    .in_src_len        (in_src_len),
    .in_dst_digits     (in_dst_digits),
    .in_dst_len        (in_dst_len),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_new_map       (out_new_map),
    .out_result_digits (out_result_digits),
    .out_result_len    (out_result_len),
    .out_cycle_found   (out_cycle_found)
  );

endmodule
